// ===== sv/doe_mailbox_discovery_defines.svh =====
// assertion macros for the mailbox core rtl
`ifndef DOE_MAILBOX_DISCOVERY_DEFINES_SVH
`define DOE_MAILBOX_DISCOVERY_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DOE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mailbox check failed");

// antecedent implies consequent in the next cycle
`define DOE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mailbox check failed");

`endif

// ===== sv/doe_mb_pkg.sv =====
package doe_mb_pkg;

    localparam int REQ_DEPTH = 256;
    localparam int REQ_AW    = $clog2(REQ_DEPTH);
    localparam int REQ_CW    = $clog2(REQ_DEPTH + 1);

    localparam int RSP_DEPTH = 4;
    localparam int TBL_SIZE  = 4;

    localparam logic [31:0] OFS_CONTROL = 32'h0000_0008;
    localparam logic [31:0] OFS_STATUS  = 32'h0000_000C;
    localparam logic [31:0] OFS_WDATA   = 32'h0000_0010;
    localparam logic [31:0] OFS_RDATA   = 32'h0000_0014;

    localparam logic [31:0] ST_ERROR = 32'h0000_0004;
    localparam logic [31:0] ST_READY = 32'h8000_0000;

    localparam int CT_ABORT_BIT = 0;
    localparam int CT_GO_BIT    = 31;

    localparam logic [15:0] VID_PCISIG = 16'h0001;
    localparam logic [15:0] VID_CXL    = 16'h1E98;
    localparam logic [7:0]  TYPE_DISC  = 8'h00;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // fixed request dwords looked at by go
    localparam logic [REQ_AW-1:0] HDR_ADDR = REQ_AW'(0);
    localparam logic [REQ_AW-1:0] IDX_ADDR = REQ_AW'(2);

    typedef struct packed {
        logic              en;
        logic [REQ_AW-1:0] addr;
        logic [31:0]       data;
    } t_ram_wr;

    typedef logic [31:0] t_tbl [TBL_SIZE];

    localparam t_tbl PROTO_TBL = '{
        {8'h00, 8'h00, VID_PCISIG},
        {8'h00, 8'h01, VID_PCISIG},
        {8'h00, 8'h02, VID_PCISIG},
        {8'h00, 8'h02, VID_CXL}
    };

    // discovery response dword, sel picks the dword, idx is the requested index
    function automatic logic [31:0] rsp_word(input logic [1:0] sel, input logic [7:0] idx);
        logic [31:0] w;
        w = '0;
        unique case (sel)
            2'd0: w = 32'(VID_PCISIG);
            2'd1: w = 32'(RSP_DEPTH);
            2'd2: w = (idx < 8'(TBL_SIZE)) ? PROTO_TBL[idx[1:0]] : '0;
            2'd3: w = (idx + 8'd1 < 8'(TBL_SIZE)) ? 32'(idx + 8'd1) : '0;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/doe_mb_if.sv =====
interface doe_mb_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] address;
    logic [31:0] write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink (input valid, input operation, input address, input write_data,
                  output ready);
endinterface

interface doe_mb_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

// ===== sv/doe_mb_req_ram.sv =====
module doe_mb_req_ram (
    input  logic                        i_clk,
    input  doe_mb_pkg::t_ram_wr         i_wr,
    input  logic [doe_mb_pkg::REQ_AW-1:0] i_raddr_a,
    input  logic [doe_mb_pkg::REQ_AW-1:0] i_raddr_b,
    output logic [31:0]                 o_rdata_a,
    output logic [31:0]                 o_rdata_b
);

    logic [31:0] r_mem [doe_mb_pkg::REQ_DEPTH];
    logic [31:0] r_rdata_a;
    logic [31:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== sv/doe_mb_core.sv =====
`include "doe_mailbox_discovery_defines.svh"

module doe_mb_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic                          i_operation,
    input  logic [31:0]                   i_address,
    input  logic [31:0]                   i_write_data,
    input  logic [31:0]                   i_hdr_dword,
    input  logic [31:0]                   i_idx_dword,
    output doe_mb_pkg::t_ram_wr           o_ram_wr,
    output logic [doe_mb_pkg::REQ_AW-1:0] o_raddr_hdr,
    output logic [doe_mb_pkg::REQ_AW-1:0] o_raddr_idx,
    output logic [31:0]                   o_read_data,
    output logic                          o_busy
);

    localparam int CW = doe_mb_pkg::REQ_CW;

    logic [31:0]   r_status,   n_status;
    logic [CW-1:0] r_req_cnt,  n_req_cnt;
    logic [2:0]    r_rsp_cnt,  n_rsp_cnt;
    logic [2:0]    r_rsp_idx,  n_rsp_idx;
    logic [31:0]   r_base,     n_base;
    logic          r_found,    n_found;
    logic          r_go_pend,  n_go_pend;
    logic [CW-1:0] r_go_cnt,   n_go_cnt;
    logic [7:0]    r_disc_idx, n_disc_idx;

    logic [31:0] base_eff;
    logic [31:0] ofs;
    logic        is_ctrl_go;

    assign o_raddr_hdr = doe_mb_pkg::HDR_ADDR;
    assign o_raddr_idx = doe_mb_pkg::IDX_ADDR;
    assign o_busy      = r_go_pend;

    // first read fixes the base so that it lands on the status register
    assign base_eff = r_found ? r_base : (i_address - doe_mb_pkg::OFS_STATUS);
    assign ofs      = i_address - base_eff;

    assign is_ctrl_go = i_acc && i_operation && r_found && (ofs == doe_mb_pkg::OFS_CONTROL)
                        && i_write_data[doe_mb_pkg::CT_GO_BIT];

    always_comb begin
        n_status    = r_status;
        n_req_cnt   = r_req_cnt;
        n_rsp_cnt   = r_rsp_cnt;
        n_rsp_idx   = r_rsp_idx;
        n_base      = r_base;
        n_found     = r_found;
        n_go_pend   = 1'b0;
        n_go_cnt    = r_go_cnt;
        n_disc_idx  = r_disc_idx;
        o_read_data = '0;
        o_ram_wr    = '0;

        if (r_go_pend) begin
            // request dwords were captured by the ram at the go beat
            if (r_go_cnt < CW'(2)) begin
                n_status = doe_mb_pkg::ST_ERROR;
            end else if (i_hdr_dword[15:0] == doe_mb_pkg::VID_PCISIG
                         && i_hdr_dword[23:16] == doe_mb_pkg::TYPE_DISC) begin
                if (r_go_cnt < CW'(3)) begin
                    n_status = doe_mb_pkg::ST_ERROR;
                end else begin
                    n_disc_idx = i_idx_dword[7:0];
                    n_rsp_cnt  = 3'(doe_mb_pkg::RSP_DEPTH);
                    n_rsp_idx  = '0;
                    n_status   = doe_mb_pkg::ST_READY;
                end
            end else begin
                n_status = doe_mb_pkg::ST_ERROR;
            end
        end else if (i_acc) begin
            if (!i_operation) begin
                if (!r_found) begin
                    n_base  = base_eff;
                    n_found = 1'b1;
                end
                if (ofs == doe_mb_pkg::OFS_STATUS) begin
                    o_read_data = r_status;
                end else if (ofs == doe_mb_pkg::OFS_RDATA) begin
                    if (r_rsp_idx >= r_rsp_cnt) begin
                        o_read_data = doe_mb_pkg::ALL_ONES;
                    end else begin
                        o_read_data = doe_mb_pkg::rsp_word(r_rsp_idx[1:0], r_disc_idx);
                    end
                end
            end else if (r_found) begin
                if (ofs == doe_mb_pkg::OFS_CONTROL) begin
                    n_go_cnt = r_req_cnt;
                    if (i_write_data[doe_mb_pkg::CT_ABORT_BIT]) begin
                        n_req_cnt = '0;
                        n_rsp_cnt = '0;
                        n_rsp_idx = '0;
                        n_status  = '0;
                        n_go_cnt  = '0;
                    end
                    if (i_write_data[doe_mb_pkg::CT_GO_BIT]) begin
                        n_go_pend = 1'b1;
                        n_req_cnt = '0;
                    end
                end else if (ofs == doe_mb_pkg::OFS_WDATA) begin
                    if (r_req_cnt < CW'(doe_mb_pkg::REQ_DEPTH)) begin
                        o_ram_wr.en   = 1'b1;
                        o_ram_wr.addr = r_req_cnt[doe_mb_pkg::REQ_AW-1:0];
                        o_ram_wr.data = i_write_data;
                        n_req_cnt     = r_req_cnt + CW'(1);
                    end
                end else if (ofs == doe_mb_pkg::OFS_RDATA) begin
                    if (i_write_data == '0) begin
                        if (r_rsp_idx + 3'd1 >= r_rsp_cnt) begin
                            n_status  = '0;
                            n_rsp_idx = '0;
                            n_rsp_cnt = '0;
                        end else begin
                            n_rsp_idx = r_rsp_idx + 3'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= '0;
            r_req_cnt <= '0;
            r_rsp_cnt <= '0;
            r_rsp_idx <= '0;
            r_base    <= '0;
            r_found   <= 1'b0;
            r_go_pend <= 1'b0;
        end else begin
            r_status  <= n_status;
            r_req_cnt <= n_req_cnt;
            r_rsp_cnt <= n_rsp_cnt;
            r_rsp_idx <= n_rsp_idx;
            r_base    <= n_base;
            r_found   <= n_found;
            r_go_pend <= n_go_pend;
        end
        r_go_cnt   <= n_go_cnt;
        r_disc_idx <= n_disc_idx;
    end

    `DOE_ASSERT_NOW(a_no_acc_in_go, i_acc, !r_go_pend)
    `DOE_ASSERT_NOW(a_req_cnt_range, 1'b1, r_req_cnt <= CW'(doe_mb_pkg::REQ_DEPTH))
    `DOE_ASSERT_NOW(a_rsp_idx_empty, r_rsp_cnt == 3'd0, r_rsp_idx == 3'd0)
    `DOE_ASSERT_NEXT(a_go_clears_cnt, is_ctrl_go, r_go_pend && r_req_cnt == '0)

endmodule

// ===== sv/doe_mailbox_discovery.sv =====
// doe mailbox with discovery, register-access front end
// i_req carries one register access per beat: operation (0 read, 1 write),
// byte address and write data. o_rsp returns one beat per request with the
// read data (zero for writes).
// the first read fixes the capability base so that its address is the status
// register; writes seen before that read are dropped but still answered.
// the request dwords live in a synchronous ram with a registered read;
// go reads header and index dwords from it at fixed addresses.
// the answer is registered and appears in the cycle after the request beat.
// throughput: one access per cycle while the receiver is not stalled, except
// that after a control write with go set the following cycle applies the go
// decision to the state from the ram read data and no request is taken then.
// reset (synchronous, active low) clears status, request and response counts,
// base and output valid; ram contents are not cleared and need no clearing pass.
// a stalled receiver holds the output register; a new request is still taken
// in the cycle the held answer leaves, unless a go is pending.
module doe_mailbox_discovery (
    input  logic         i_clk,
    input  logic         i_rst_n,
    doe_mb_req_if.sink   i_req,
    doe_mb_rsp_if.source o_rsp
);

    doe_mb_pkg::t_ram_wr           ram_wr;
    logic [doe_mb_pkg::REQ_AW-1:0] raddr_hdr;
    logic [doe_mb_pkg::REQ_AW-1:0] raddr_idx;
    logic [31:0]                   hdr_dword;
    logic [31:0]                   idx_dword;
    logic [31:0]                   core_rdata;
    logic                          busy;
    logic                          acc;

    logic        r_out_valid;
    logic [31:0] r_out_data;

    // take a beat when the output slot is free or draining, and no go is pending
    assign i_req.ready = (!r_out_valid || o_rsp.ready) && !busy;
    assign acc         = i_req.valid && i_req.ready;

    doe_mb_req_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_raddr_a (raddr_hdr),
        .i_raddr_b (raddr_idx),
        .o_rdata_a (hdr_dword),
        .o_rdata_b (idx_dword)
    );

    doe_mb_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_operation  (i_req.operation),
        .i_address    (i_req.address),
        .i_write_data (i_req.write_data),
        .i_hdr_dword  (hdr_dword),
        .i_idx_dword  (idx_dword),
        .o_ram_wr     (ram_wr),
        .o_raddr_hdr  (raddr_hdr),
        .o_raddr_idx  (raddr_idx),
        .o_read_data  (core_rdata),
        .o_busy       (busy)
    );

    // output register, one answer beat per request beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (acc) begin
            r_out_data <= core_rdata;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;

endmodule
